>>> design/mcm_pkg.sv
// mcm_pkg: shared constants and the per-item control struct of the
// matrix chain multiplier; no dependencies
`default_nettype none

package mcm_pkg;

    localparam int unsigned ELEM_W   = 32;
    localparam int unsigned DIM_DEF  = 4;
    localparam int unsigned FRAC_DEF = 16;

    // control flags of one item as it moves down the pipeline
    typedef struct packed {
        logic valid;
        logic load;       // element of the first matrix of a chain
        logic mac;        // element of a later matrix
        logic complete;   // last element of a matrix
        logic emit;       // completes the final matrix of a chain
    } item_ctl_t;

endpackage

`default_nettype wire

>>> design/mcm_ctrl.sv
// mcm_ctrl: element position tracking, input register and multiply-stage
// control of the matrix chain multiplier; uses mcm_pkg
`default_nettype none

module mcm_ctrl #(
    parameter int unsigned DIM = mcm_pkg::DIM_DEF,
    localparam int unsigned CW = $clog2(DIM)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    input  wire logic [mcm_pkg::ELEM_W-1:0]  elem,
    input  wire logic                        starts_chain,
    input  wire logic                        ends_chain,
    input  wire logic                        emit_busy,
    output logic                             advance,
    output mcm_pkg::item_ctl_t               in_ctl,
    output logic [CW-1:0]                    in_col,
    output logic [CW-1:0]                    in_row,
    output logic [mcm_pkg::ELEM_W-1:0]       in_elem,
    output mcm_pkg::item_ctl_t               mul_ctl,
    output logic [CW-1:0]                    mul_col,
    output logic [CW-1:0]                    mul_row
);

    localparam logic [CW-1:0] LAST_IDX = CW'(DIM - 1);

    logic [CW-1:0]                  col_reg, col_next;
    logic [CW-1:0]                  row_reg, row_next;
    logic                           loading_reg, loading_next;
    mcm_pkg::item_ctl_t             in_ctl_reg, mul_ctl_reg;
    mcm_pkg::item_ctl_t             dec_ctl;
    logic [CW-1:0]                  in_col_reg, in_row_reg;
    logic [CW-1:0]                  mul_col_reg, mul_row_reg;
    logic [mcm_pkg::ELEM_W-1:0]     in_elem_reg;
    logic                           accept;
    logic                           ld;
    logic [CW-1:0]                  cur_col, cur_row;
    logic                           complete;

    // the whole pipeline holds only while a finished product waits for the emitter
    assign advance = !(mul_ctl_reg.valid && mul_ctl_reg.emit && emit_busy);
    assign accept  = s_tvalid && advance;

    // a chain start restarts the position and the first-matrix load
    assign ld       = starts_chain || loading_reg;
    assign cur_col  = starts_chain ? '0 : col_reg;
    assign cur_row  = starts_chain ? '0 : row_reg;
    assign complete = (cur_col == LAST_IDX) && (cur_row == LAST_IDX);

    always_comb begin
        row_next     = row_reg;
        col_next     = col_reg;
        loading_next = loading_reg;
        if (accept) begin
            row_next = (cur_row == LAST_IDX) ? '0 : cur_row + 1'b1;
            if (cur_row == LAST_IDX) begin
                col_next = complete ? '0 : cur_col + 1'b1;
            end else begin
                col_next = cur_col;
            end
            loading_next = ld ? (!complete || ends_chain) : (complete && ends_chain);
        end
    end

    always_comb begin
        dec_ctl.valid    = accept;
        dec_ctl.load     = ld;
        dec_ctl.mac      = !ld;
        dec_ctl.complete = complete;
        dec_ctl.emit     = complete && ends_chain;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            loading_reg <= 1'b1;
            in_ctl_reg  <= '0;
            mul_ctl_reg <= '0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            loading_reg <= loading_next;
            if (advance) begin
                in_ctl_reg  <= dec_ctl;
                mul_ctl_reg <= in_ctl_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_col_reg  <= cur_col;
            in_row_reg  <= cur_row;
            in_elem_reg <= elem;
            mul_col_reg <= in_col_reg;
            mul_row_reg <= in_row_reg;
        end
    end

    assign in_ctl  = in_ctl_reg;
    assign in_col  = in_col_reg;
    assign in_row  = in_row_reg;
    assign in_elem = in_elem_reg;
    assign mul_ctl = mul_ctl_reg;
    assign mul_col = mul_col_reg;
    assign mul_row = mul_row_reg;

endmodule

`default_nettype wire

>>> design/mcm_lane.sv
// mcm_lane: one row lane of the matrix chain multiplier: running product row,
// finished partial columns, multiplier, product register and accumulator; uses mcm_pkg
`default_nettype none

module mcm_lane #(
    parameter int unsigned DIM  = mcm_pkg::DIM_DEF,
    parameter int unsigned FRAC = mcm_pkg::FRAC_DEF,
    parameter int unsigned LANE = 0,
    localparam int unsigned CW  = $clog2(DIM)
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 advance,
    input  wire mcm_pkg::item_ctl_t                   in_ctl,
    input  wire logic [CW-1:0]                        in_col,
    input  wire logic [CW-1:0]                        in_row,
    input  wire logic [mcm_pkg::ELEM_W-1:0]           in_elem,
    input  wire mcm_pkg::item_ctl_t                   mul_ctl,
    input  wire logic [CW-1:0]                        mul_col,
    input  wire logic [CW-1:0]                        mul_row,
    output logic [DIM-1:0][mcm_pkg::ELEM_W-1:0]       new_vals
);

    localparam int unsigned EW = mcm_pkg::ELEM_W;
    localparam int unsigned FW = 2 * EW;
    localparam int unsigned PW = FW - FRAC;
    localparam int unsigned W  = PW + $clog2(DIM);
    localparam logic [CW-1:0] LAST_IDX = CW'(DIM - 1);

    logic [EW-1:0]          run_reg [DIM];   // this row of the running product, by column
    logic [EW-1:0]          cst_reg [DIM];   // finished columns of the matrix in progress
    logic signed [PW-1:0]   prod_reg;
    logic signed [W-1:0]    acc_reg;
    logic                   fwd;
    logic signed [EW-1:0]   src;
    logic signed [FW-1:0]   full_prod;
    logic signed [W-1:0]    acc_base;
    logic signed [W-1:0]    sum;
    logic [EW-1:0]          sat_val;
    logic                   in_range;

    // a product that commits this cycle is read from the finished columns
    assign fwd = mul_ctl.valid && mul_ctl.mac && mul_ctl.complete;
    assign src = $signed(fwd ? cst_reg[in_row] : run_reg[in_row]);

    assign full_prod = FW'(src) * FW'($signed(in_elem));

    assign acc_base = (mul_row == '0) ? '0 : acc_reg;
    assign sum      = acc_base + W'(prod_reg);

    // saturate when the upper bits are not all copies of the sign
    assign in_range = (sum[W-1:EW-1] == '0) || (sum[W-1:EW-1] == '1);
    assign sat_val  = in_range ? sum[EW-1:0]
                    : (sum[W-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}});

    always_comb begin
        for (int c = 0; c < DIM; c++) begin
            if (mul_ctl.mac) begin
                new_vals[c] = (c == DIM - 1) ? sat_val : cst_reg[c];
            end else begin
                new_vals[c] = run_reg[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (mul_ctl.valid && mul_ctl.mac) begin
                acc_reg <= sum;
                if (mul_row == LAST_IDX) begin
                    cst_reg[mul_col] <= sat_val;
                end
                if (mul_ctl.complete) begin
                    for (int c = 0; c < DIM; c++) begin
                        run_reg[c] <= new_vals[c];
                    end
                end
            end
            // a load of a new chain wins over an older commit
            if (in_ctl.valid && in_ctl.load && (in_row == CW'(LANE))) begin
                run_reg[in_col] <= in_elem;
            end
            if (in_ctl.valid && in_ctl.mac) begin
                prod_reg <= full_prod[FW-1:FRAC];
            end
        end
    end

    // the last column is never needed right after a matrix completes
    a_no_fwd_last_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_ctl.valid && in_ctl.mac && fwd) |-> (in_row != LAST_IDX))
        else $error("forwarded read of the column still being committed");

endmodule

`default_nettype wire

>>> design/mcm_emit.sv
// mcm_emit: product snapshot and shift-out sequencer of the matrix chain
// multiplier; uses mcm_pkg
`default_nettype none

module mcm_emit #(
    parameter int unsigned DIM = mcm_pkg::DIM_DEF,
    localparam int unsigned IW = $clog2(DIM * DIM)
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          load_en,
    input  wire logic [DIM-1:0][DIM-1:0][mcm_pkg::ELEM_W-1:0]  vals,   // [row][col]
    input  wire logic                                          m_tready,
    output logic                                               m_tvalid,
    output logic [mcm_pkg::ELEM_W-1:0]                         prod_elem,
    output logic [IW-1:0]                                      prod_index,
    output logic                                               prod_last,
    output logic                                               busy
);

    localparam int unsigned NELEM = DIM * DIM;

    logic [mcm_pkg::ELEM_W-1:0]  line_reg [NELEM];   // column-major, head at entry 0
    logic [IW-1:0]               idx_reg;
    logic                        busy_reg;
    logic                        take;

    assign take      = busy_reg && m_tready;
    assign prod_last = (idx_reg == IW'(NELEM - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load_en) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (take) begin
            if (prod_last) begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            for (int c = 0; c < DIM; c++) begin
                for (int r = 0; r < DIM; r++) begin
                    line_reg[c * DIM + r] <= vals[r][c];
                end
            end
        end else if (take) begin
            for (int k = 0; k < NELEM - 1; k++) begin
                line_reg[k] <= line_reg[k + 1];
            end
        end
    end

    assign m_tvalid   = busy_reg;
    assign prod_elem  = line_reg[0];
    assign prod_index = idx_reg;
    assign busy       = busy_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_en |-> !busy_reg)
        else $error("product snapshot loaded while still streaming");

endmodule

`default_nettype wire

>>> design/matrix4_chain_multiply.sv
// matrix4_chain_multiply: top level of the DIM x DIM matrix chain multiplier
// depends on mcm_pkg, mcm_ctrl, mcm_lane and mcm_emit
`default_nettype none

// Multiplies a chain of DIM x DIM column-major matrices left to right in signed
// fixed point (Q16.16 at FRAC_BITS = 16). Elements enter one per item in
// column-major order, s_tuser high on the first element of a chain (it aborts
// any chain in progress) and s_tlast high on the last element of the chain's
// final matrix (ignored on any other element). The block takes one element
// every cycle: an element is registered, its DIM row products are formed by
// DIM parallel 32x32 multipliers into a product register, and a following
// stage adds them into the per-row column sums. Each product is shifted right
// arithmetically by FRAC_BITS (rounding toward minus infinity), sums are kept
// wide, and each element saturates to 32 bits when its column completes.
// A finished product is copied into an output line and streamed out as DIM*DIM
// items in column-major order, the last with m_tlast; its first item is
// offered once the final element has passed the input register and the
// multiply stage and the product sits in the output line. A chain of one
// matrix comes out unchanged. Input stalls (s_tready low) only while a newly
// finished product waits for the previous one to finish streaming.
module matrix4_chain_multiply #(
    parameter int unsigned DIM       = mcm_pkg::DIM_DEF,    // 2 to 8
    parameter int unsigned FRAC_BITS = mcm_pkg::FRAC_DEF,   // 8 to 24
    localparam int unsigned IW = $clog2(DIM * DIM),
    localparam int unsigned DW = ((mcm_pkg::ELEM_W + IW + 7) / 8) * 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // input items
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [mcm_pkg::ELEM_W-1:0]  s_tdata,    // elem
    input  wire logic                        s_tuser,    // starts_chain
    input  wire logic                        s_tlast,    // ends_chain
    // result items
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [DW-1:0]                    m_tdata,    // prod_elem, prod_index, zero fill
    output logic                             m_tlast     // prod_last
);

    localparam int unsigned CW = $clog2(DIM);
    localparam int unsigned EW = mcm_pkg::ELEM_W;

    logic                                 advance;
    mcm_pkg::item_ctl_t                   in_ctl, mul_ctl;
    logic [CW-1:0]                        in_col, in_row, mul_col, mul_row;
    logic [EW-1:0]                        in_elem;
    logic [DIM-1:0][DIM-1:0][EW-1:0]      lane_vals;   // [row][col]
    logic                                 emit_busy;
    logic                                 emit_load;
    logic [EW-1:0]                        prod_elem;
    logic [IW-1:0]                        prod_index;

    // position tracking, input register and multiply-stage control
    mcm_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .elem         (s_tdata),
        .starts_chain (s_tuser),
        .ends_chain   (s_tlast),
        .emit_busy    (emit_busy),
        .advance      (advance),
        .in_ctl       (in_ctl),
        .in_col       (in_col),
        .in_row       (in_row),
        .in_elem      (in_elem),
        .mul_ctl      (mul_ctl),
        .mul_col      (mul_col),
        .mul_row      (mul_row)
    );

    assign s_tready = advance;

    // one lane per result row, each with its own multiplier and accumulator
    for (genvar r = 0; r < DIM; r++) begin : g_lane
        mcm_lane #(
            .DIM  (DIM),
            .FRAC (FRAC_BITS),
            .LANE (r)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .in_ctl   (in_ctl),
            .in_col   (in_col),
            .in_row   (in_row),
            .in_elem  (in_elem),
            .mul_ctl  (mul_ctl),
            .mul_col  (mul_col),
            .mul_row  (mul_row),
            .new_vals (lane_vals[r])
        );
    end

    // snapshot the product when the chain's final element commits
    assign emit_load = advance && mul_ctl.valid && mul_ctl.emit;

    mcm_emit #(
        .DIM (DIM)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_en    (emit_load),
        .vals       (lane_vals),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .prod_elem  (prod_elem),
        .prod_index (prod_index),
        .prod_last  (m_tlast),
        .busy       (emit_busy)
    );

    assign m_tdata = {{(DW - EW - IW){1'b0}}, prod_index, prod_elem};

    // the emitter goes idle after the last element of a product
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("result stream continued past the last element");

    // input only stalls behind a product that is still streaming
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no product streaming");

endmodule

`default_nettype wire

>>> sim/tb_matrix4_chain_multiply.sv
// tb_matrix4_chain_multiply: self-checking bench for the 4x4 matrix chain multiplier
// depends on mcm_pkg and matrix4_chain_multiply; predicts every product element
`default_nettype none

module tb_matrix4_chain_multiply;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DIM       = mcm_pkg::DIM_DEF;
    localparam int unsigned FRAC_BITS = mcm_pkg::FRAC_DEF;
    localparam int unsigned NELEM     = DIM * DIM;
    localparam int unsigned IW        = $clog2(NELEM);
    localparam int unsigned DW        = ((mcm_pkg::ELEM_W + IW + 7) / 8) * 8;
    localparam int unsigned N_DIR     = 23;
    localparam int unsigned HOLD_CYCLES = 300;   // long output stall under pressure
    localparam int unsigned QUIET_LIMIT = 4000;  // cycles with no handshake at all
    localparam int unsigned DRAIN_CYCLES = 32;

    // one product element as it leaves the block
    typedef struct packed {
        logic [31:0]   elem;
        logic [IW-1:0] idx;
        logic          last;
    } prod_item_t;

    // directed row: element, chain start, chain end, typed result, typed value
    typedef struct packed {
        logic [31:0] elem;
        logic        first;
        logic        fin;
        logic        typed;
        logic [31:0] want;
    } dir_row_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    wire logic                     s_tready;
    logic [mcm_pkg::ELEM_W-1:0]    s_tdata  = '0;
    logic                          s_tuser  = 1'b0;
    logic                          s_tlast  = 1'b0;
    wire logic                     m_tvalid;
    logic                          m_tready = 1'b0;
    wire logic [DW-1:0]            m_tdata;
    wire logic                     m_tlast;

    // predictor state: running product, wide column sums, position, first-matrix flag
    logic signed [31:0] running_q16 [NELEM];
    longint             col_sums    [NELEM];
    int unsigned        elem_pos  = 0;
    bit                 first_mat = 1'b1;

    prod_item_t  product_q [$];
    logic [31:0] typed_prod [NELEM];
    int unsigned typed_n      = 0;
    int unsigned items_sent   = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned idle_pct     = 0;
    int unsigned stall_pct    = 0;
    bit          hold_go      = 1'b0;
    int unsigned hold_cnt     = 0;
    int unsigned quiet_cycles = 0;

    dir_row_t dir_rows [N_DIR] = '{
        // single matrix chain of extremes, comes out unchanged
        '{32'h8000_0000, 1'b1, 1'b0, 1'b1, 32'h8000_0000},
        '{32'h7fff_ffff, 1'b0, 1'b0, 1'b1, 32'h7fff_ffff},
        '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 32'h0000_0000},
        '{32'hffff_ffff, 1'b0, 1'b0, 1'b1, 32'hffff_ffff},
        '{32'h0000_0001, 1'b0, 1'b0, 1'b1, 32'h0000_0001},
        '{32'h0001_0000, 1'b0, 1'b0, 1'b1, 32'h0001_0000},
        // end mark before the sixteenth element is ignored
        '{32'hffff_0000, 1'b0, 1'b1, 1'b1, 32'hffff_0000},
        '{32'h5555_5555, 1'b0, 1'b0, 1'b1, 32'h5555_5555},
        '{32'haaaa_aaaa, 1'b0, 1'b0, 1'b1, 32'haaaa_aaaa},
        '{32'h7fff_0000, 1'b0, 1'b0, 1'b1, 32'h7fff_0000},
        '{32'h8001_0000, 1'b0, 1'b0, 1'b1, 32'h8001_0000},
        '{32'h0000_8000, 1'b0, 1'b0, 1'b1, 32'h0000_8000},
        '{32'hffff_8000, 1'b0, 1'b0, 1'b1, 32'hffff_8000},
        '{32'h1234_5678, 1'b0, 1'b0, 1'b1, 32'h1234_5678},
        '{32'hedcb_a987, 1'b0, 1'b0, 1'b1, 32'hedcb_a987},
        '{32'h0000_ffff, 1'b0, 1'b1, 1'b1, 32'h0000_ffff},
        // new chain without a start mark after a finished one
        '{32'h0002_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{32'h0003_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{32'hfffe_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        // start mark mid-matrix aborts the chain, early end mark on top
        '{32'h7fff_ffff, 1'b1, 1'b1, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0}
    };

    matrix4_chain_multiply u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // elem
        .s_tuser  (s_tuser),     // starts_chain
        .s_tlast  (s_tlast),     // ends_chain
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // prod_elem, prod_index, zero fill
        .m_tlast  (m_tlast)      // prod_last
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] clamp_q16(longint v);
        if (v > longint'(32'sh7fff_ffff))
            return 32'h7fff_ffff;
        if (v < -longint'(32'sh7fff_ffff) - 1)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // steps the predictor by one element, returns 1 when a chain's product is ready
    function automatic bit advance_chain(logic signed [31:0] e, logic first, logic fin);
        int unsigned col;
        int unsigned row;
        bit          complete;
        longint      prod;
        if (first) begin
            elem_pos  = 0;
            first_mat = 1'b1;
            foreach (col_sums[k]) col_sums[k] = 0;
        end
        complete = (elem_pos == NELEM - 1);
        if (first_mat) begin
            running_q16[elem_pos] = e;
            elem_pos = complete ? 0 : elem_pos + 1;
            if (complete) begin
                foreach (col_sums[k]) col_sums[k] = 0;
                if (fin)
                    return 1'b1;
                first_mat = 1'b0;
            end
            return 1'b0;
        end
        // element b[col][row] scales column row of the running product
        col = elem_pos / DIM;
        row = elem_pos % DIM;
        for (int r = 0; r < DIM; r++) begin
            prod = longint'(running_q16[row * DIM + r]) * longint'(e);
            col_sums[col * DIM + r] += prod >>> FRAC_BITS;
        end
        elem_pos = complete ? 0 : elem_pos + 1;
        if (complete) begin
            foreach (col_sums[k]) begin
                running_q16[k] = clamp_q16(col_sums[k]);
                col_sums[k]    = 0;
            end
            if (fin) begin
                first_mat = 1'b1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // one element through the slave channel, with random gaps ahead of it
    task automatic send_elem(input logic [31:0] e, input logic first, input logic fin,
                             input bit typed);
        prod_item_t p;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= e;
        s_tuser  <= first;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (advance_chain(e, first, fin)) begin
            for (int k = 0; k < NELEM; k++) begin
                p.elem = typed ? typed_prod[k] : running_q16[k];
                p.idx  = k[IW-1:0];
                p.last = (k == NELEM - 1);
                product_q.push_back(p);
            end
            typed_n = 0;
        end
    endtask

    // value mixes: small Q16.16, small integers, full range, extremes
    function automatic logic [31:0] rand_elem(int unsigned style);
        case (style)
            0: return 32'(int'($urandom_range(0, 2**19)) - 2**18);
            1: return 32'((int'($urandom_range(0, 4)) - 2) <<< FRAC_BITS);
            2: return $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    // one chain of whole matrices; n_req = 0 picks length and may break it off
    task automatic send_chain(input int unsigned n_req);
        int unsigned n_mat;
        int unsigned style;
        int          stop_at;
        bit          at_rest;
        logic        first;
        logic        fin;
        n_mat = n_req;
        if (n_req == 0)
            n_mat = ($urandom_range(0, 5) == 0) ? 3 : $urandom_range(1, 2);
        stop_at = -1;
        if (n_req == 0 && $urandom_range(0, 9) == 0)
            stop_at = $urandom_range(1, n_mat * NELEM - 1);
        // start mark may be left off only when no chain is in progress
        at_rest = (elem_pos == 0) && first_mat;
        for (int m = 0; m < n_mat; m++) begin
            style = $urandom_range(0, 9);
            style = (style < 5) ? 0 : (style < 7) ? 1 : (style < 9) ? 2 : 3;
            for (int k = 0; k < NELEM; k++) begin
                if (m * NELEM + k == stop_at)
                    return;
                first = (m == 0 && k == 0) && (!at_rest || $urandom_range(0, 3) != 0);
                if (k == NELEM - 1)
                    fin = (m == n_mat - 1);
                else
                    fin = ($urandom_range(0, 7) == 0);
                send_elem(rand_elem(style), first, fin, 1'b0);
            end
        end
    endtask

    // receiver: long hold-off once when asked, random stalls otherwise
    always @(posedge aclk) begin
        if (hold_go && hold_cnt < HOLD_CYCLES) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result check against the oldest predicted element
    always @(posedge aclk) begin : check_results
        prod_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (product_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected item: elem %h idx %0d last %b",
                             m_tdata[31:0], m_tdata[32 +: IW], m_tlast);
            end else begin
                want = product_q.pop_front();
                if (m_tdata[31:0] !== want.elem || m_tdata[32 +: IW] !== want.idx ||
                    m_tlast !== want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp elem %h idx %0d last %b, got %h %0d %b",
                                 want.elem, want.idx, want.last,
                                 m_tdata[31:0], m_tdata[32 +: IW], m_tlast);
                end
            end
        end
    end

    // watchdog on cycles in which neither channel moves an item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows
        for (int i = 0; i < N_DIR; i++) begin
            if (dir_rows[i].typed) begin
                typed_prod[typed_n] = dir_rows[i].want;
                typed_n++;
            end
            send_elem(dir_rows[i].elem, dir_rows[i].first, dir_rows[i].fin,
                      dir_rows[i].typed);
        end

        // random chains: no idling, sender idle, receiver stalling
        for (int ph = 0; ph < 3; ph++) begin
            int unsigned phase_base;
            idle_pct   = (ph == 1) ? 85 : 0;
            stall_pct  = (ph == 2) ? 85 : 0;
            phase_base = items_sent;
            while (items_sent - phase_base < 32)
                send_chain(0);
        end

        // receiver holds off while whole chains keep coming, input backs up
        idle_pct  = 0;
        stall_pct = 0;
        hold_go   = 1'b1;
        repeat (3) send_chain(1);
        // sender pauses until every product element has come out
        s_tvalid <= 1'b0;
        while (product_q.size() != 0) @(posedge aclk);

        // both sides idling now and then
        begin
            int unsigned phase_base;
            idle_pct   = 16;
            stall_pct  = 16;
            phase_base = items_sent;
            while (items_sent - phase_base < 32)
                send_chain(0);
            s_tvalid <= 1'b0;
        end

        while (product_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0 && product_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

>>> matrix4_chain_multiply.f
design/mcm_pkg.sv
design/mcm_ctrl.sv
design/mcm_lane.sv
design/mcm_emit.sv
design/matrix4_chain_multiply.sv
sim/tb_matrix4_chain_multiply.sv
